// File: design/radix_integer_text_parser_unit_assert.svh
// Assertion macros for the integer text parser.
// Each check is clocked on i_clk and is held off while i_rst_n is low.
// Synthesis builds see empty macro bodies.
`ifndef RADIX_INTEGER_TEXT_PARSER_UNIT_ASSERT_SVH
`define RADIX_INTEGER_TEXT_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RITP_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ritp check failed");

// The consequent must hold in the cycle after the antecedent.
`define RITP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ritp check failed");

`else

`define RITP_ASSERT_SAME(name, ante, cons)
`define RITP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: design/ritp_pkg.sv
package ritp_pkg;

    // Default accumulator width.
    localparam int VALUE_BITS_DEF = 64;

    // Width of the parsed value on the result port.
    localparam int RESULT_BITS = 64;

    // Reset value of the radix register.
    localparam logic [5:0] RADIX_RESET = 6'd10;

    // Configuration register indexes.
    localparam logic CFG_RADIX      = 1'b0;
    localparam logic CFG_HEX_PREFIX = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    // Digit value of the first letter.
    localparam logic [7:0] LETTER_DIGIT_BASE = 8'd10;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_ZERO    = 4'b0010,
        PH_SIGN_OK = 4'b0100,
        PH_DIGITS  = 4'b1000
    } t_phase;

    // Decoded form of one input item.
    typedef struct packed {
        logic [5:0] digit;
        logic       alnum;
        logic       is_zero;
        logic       is_x;
        logic       is_minus;
        logic       eot;
    } t_char_class;

    // One result item as it leaves the parse logic.
    typedef struct packed {
        logic                   done;
        logic [RESULT_BITS-1:0] value;
        logic [7:0]             count;
        logic                   ovf;
    } t_result;

    // Classify a character and find its digit value.
    function automatic t_char_class char_decode(input logic [7:0] c, input logic eot);
        t_char_class cls;
        cls.digit    = '0;
        cls.alnum    = 1'b0;
        cls.is_zero  = (c == CHAR_ZERO);
        cls.is_x     = (c == CHAR_LOWER_X);
        cls.is_minus = (c == CHAR_MINUS);
        cls.eot      = eot;
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            cls.digit = 6'(c - CHAR_ZERO);
            cls.alnum = 1'b1;
        end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            cls.digit = 6'(c - CHAR_LOWER_A + LETTER_DIGIT_BASE);
            cls.alnum = 1'b1;
        end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            cls.digit = 6'(c - CHAR_UPPER_A + LETTER_DIGIT_BASE);
            cls.alnum = 1'b1;
        end
        return cls;
    endfunction

endpackage

// File: design/radix_integer_text_parser_unit.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_text_char, i_end_of_text
// result    out        o_out_valid / i_out_ready   o_parsed_value, o_digit_count, o_overflow
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item is taken per cycle while the result side does not stall; the parse state loop is one 64x6 multiply-add.
// A result for the item that ends the number passes the decode register, then the
// parse logic into the result register.
// Reset is synchronous and active low; it restores radix 10, prefix option off, empty parse.
// While a result waits, the input register holds any decoded item and the input side stalls once it is full.
// Configuration writes are taken in every cycle.
`include "radix_integer_text_parser_unit_assert.svh"

module radix_integer_text_parser_unit #(
    parameter int VALUE_BITS = ritp_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_text_char,
    input  logic               i_end_of_text,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_parsed_value,
    output logic [7:0]         o_digit_count,
    output logic               o_overflow,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [5:0]         i_cfg_data
);

    logic [5:0]            r_radix;
    logic                  r_hex_en;

    logic                  r_in_valid;
    ritp_pkg::t_char_class r_cls;

    logic                  r_out_valid;
    logic [63:0]           r_value;
    logic [7:0]            r_count;
    logic                  r_ovf;

    logic                  s2_free;
    logic                  s2_fire;
    ritp_pkg::t_result     core_result;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= ritp_pkg::RADIX_RESET;
            r_hex_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ritp_pkg::CFG_RADIX:      r_radix  <= i_cfg_data;
                ritp_pkg::CFG_HEX_PREFIX: r_hex_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage control: the parse step runs when the result register can take its output.
    assign s2_free    = !r_out_valid || i_out_ready;
    assign s2_fire    = r_in_valid && s2_free;
    assign o_in_ready = !r_in_valid || s2_fire;

    // Input register holds the decoded item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (s2_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cls <= ritp_pkg::char_decode(i_text_char, i_end_of_text);
        end
    end

    ritp_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s2_fire),
        .i_cls    (r_cls),
        .i_radix  (r_radix),
        .i_hex_en (r_hex_en),
        .o_result (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && core_result.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && core_result.done) begin
            r_value <= core_result.value;
            r_count <= core_result.count;
            r_ovf   <= core_result.ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = $signed(r_value);
    assign o_digit_count  = r_count;
    assign o_overflow     = r_ovf;

    // A result that waits on the consumer is never overwritten by the parse step.
    `RITP_ASSERT_SAME(a_no_result_overwrite, r_out_valid && !i_out_ready, !s2_fire)
    // A finished number always lands in the result register.
    `RITP_ASSERT_NEXT(a_result_loaded, s2_fire && core_result.done, r_out_valid)
    // Overflow can only come from an accumulated digit.
    `RITP_ASSERT_SAME(a_ovf_has_digits, r_out_valid && r_ovf, r_count != 8'd0)

endmodule

// File: design/ritp_core.sv
module ritp_core #(
    parameter int VALUE_BITS = ritp_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  ritp_pkg::t_char_class i_cls,
    input  logic [5:0]            i_radix,
    input  logic                  i_hex_en,
    output ritp_pkg::t_result     o_result
);

    localparam int PROD_BITS = VALUE_BITS + 6;
    localparam int SUM_BITS  = VALUE_BITS + 7;

    ritp_pkg::t_phase        r_phase, n_phase;
    logic [VALUE_BITS-1:0]   r_mag, n_mag;
    logic                    r_neg, n_neg;
    logic [7:0]              r_count, n_count;
    logic                    r_ovf, n_ovf;

    logic [PROD_BITS-1:0]    prod;
    logic [SUM_BITS-1:0]     acc_sum;
    logic [VALUE_BITS-1:0]   acc_mag;
    logic                    acc_ovf;
    logic                    digit_ok;
    logic                    consumed;
    logic                    done;
    ritp_pkg::t_phase        mid_phase;
    logic [7:0]              fin_count;
    logic [VALUE_BITS-1:0]   signed_mag;

    // Saturating digit counter step.
    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == 8'hff) ? c : c + 8'd1;
    endfunction

    // Horner step: magnitude times radix plus digit, with the carry-out as overflow.
    always_comb begin
        prod    = PROD_BITS'(r_mag) * PROD_BITS'(i_radix);
        acc_sum = {1'b0, prod} + SUM_BITS'(i_cls.digit);
        acc_mag = acc_sum[VALUE_BITS-1:0];
        acc_ovf = |acc_sum[SUM_BITS-1:VALUE_BITS];
    end

    assign digit_ok = i_cls.alnum && (i_cls.digit < i_radix);

    // Next parse state for one item.
    always_comb begin
        n_phase  = r_phase;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_count  = r_count;
        n_ovf    = r_ovf;
        consumed = 1'b0;
        done     = 1'b0;

        // A pending '0' either opens the prefix or becomes a digit of its own.
        // The magnitude is still zero here, so only the count moves.
        if (r_phase == ritp_pkg::PH_ZERO) begin
            if (i_cls.is_x) begin
                n_phase  = ritp_pkg::PH_SIGN_OK;
                consumed = 1'b1;
            end else begin
                n_count = sat_inc(r_count);
                n_phase = ritp_pkg::PH_DIGITS;
            end
        end
        mid_phase = n_phase;

        if (!consumed) begin
            if (mid_phase == ritp_pkg::PH_START && i_hex_en && i_cls.is_zero) begin
                n_phase = ritp_pkg::PH_ZERO;
            end else if ((mid_phase == ritp_pkg::PH_START ||
                          mid_phase == ritp_pkg::PH_SIGN_OK) && i_cls.is_minus) begin
                n_neg   = 1'b1;
                n_phase = ritp_pkg::PH_DIGITS;
            end else if (digit_ok) begin
                n_mag   = acc_mag;
                n_ovf   = r_ovf | acc_ovf;
                n_count = sat_inc(n_count);
                n_phase = ritp_pkg::PH_DIGITS;
            end else begin
                done = 1'b1;
            end
        end

        if (i_cls.eot) begin
            done = 1'b1;
        end
    end

    // Result formatting: a number that ends on a lone '0' counts that digit.
    always_comb begin
        fin_count  = (n_phase == ritp_pkg::PH_ZERO) ? sat_inc(n_count) : n_count;
        signed_mag = n_neg ? ({VALUE_BITS{1'b0}} - n_mag) : n_mag;
        o_result.done  = done;
        o_result.value = ritp_pkg::RESULT_BITS'($signed(signed_mag));
        o_result.count = fin_count;
        o_result.ovf   = n_ovf;
    end

    // Parse state; a finished number clears it for the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ritp_pkg::PH_START;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_fire) begin
            if (done) begin
                r_phase <= ritp_pkg::PH_START;
                r_mag   <= '0;
                r_neg   <= 1'b0;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

// File: sim/radix_integer_text_parser_unit_tb.sv
module radix_integer_text_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 850;
    localparam int NUM_PHASES   = 9;

    // Character codes used by the stimulus beyond those of the package.
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0a;
    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_TOP     = 8'hff;

    typedef struct packed {
        logic signed [63:0] value;
        logic [7:0]         count;
        logic               ovf;
    } t_parsed_number;

    // Tracks the parse of the character stream and holds the numbers still due.
    class t_number_scoreboard;
        bit [5:0]         radix;
        bit               hex_on;
        ritp_pkg::t_phase phase;
        bit [63:0]        magnitude;
        bit               negative;
        bit [7:0]         count;
        bit               overflowed;
        t_parsed_number   expected_numbers[$];
        int               mismatches;

        function new();
            radix      = ritp_pkg::RADIX_RESET;
            hex_on     = 1'b0;
            mismatches = 0;
            clear_number();
        endfunction

        function void clear_number();
            phase      = ritp_pkg::PH_START;
            magnitude  = '0;
            negative   = 1'b0;
            count      = '0;
            overflowed = 1'b0;
        endfunction

        function void set_register(logic index, bit [5:0] data);
            if (index == ritp_pkg::CFG_RADIX) begin
                radix = data;
            end else begin
                hex_on = data[0];
            end
        endfunction

        // Digit value of a character, or all ones when it is not alphanumeric.
        function bit [7:0] digit_of(bit [7:0] c);
            if (c >= ritp_pkg::CHAR_ZERO && c <= ritp_pkg::CHAR_NINE) begin
                return c - ritp_pkg::CHAR_ZERO;
            end
            if (c >= ritp_pkg::CHAR_LOWER_A && c <= ritp_pkg::CHAR_LOWER_Z) begin
                return c - ritp_pkg::CHAR_LOWER_A + ritp_pkg::LETTER_DIGIT_BASE;
            end
            if (c >= ritp_pkg::CHAR_UPPER_A && c <= ritp_pkg::CHAR_UPPER_Z) begin
                return c - ritp_pkg::CHAR_UPPER_A + ritp_pkg::LETTER_DIGIT_BASE;
            end
            return 8'hff;
        endfunction

        // Horner step; overflow is flagged when the exact result needs more than 64 bits.
        function void add_digit(bit [7:0] d);
            bit [63:0] r;
            r = 64'(radix);
            if (r != 0 && magnitude > ({64{1'b1}} - 64'(d)) / r) begin
                overflowed = 1'b1;
            end
            magnitude = magnitude * r + 64'(d);
            if (count != 8'hff) begin
                count++;
            end
        endfunction

        // Advances the parse by one accepted item and queues a number when one ends.
        function void note_char(bit [7:0] c, bit eot);
            bit             consumed;
            bit             done;
            bit [7:0]       d;
            t_parsed_number num;
            consumed = 1'b0;
            done     = 1'b0;
            if (phase == ritp_pkg::PH_ZERO) begin
                if (c == ritp_pkg::CHAR_LOWER_X) begin
                    phase    = ritp_pkg::PH_SIGN_OK;
                    consumed = 1'b1;
                end else begin
                    add_digit(8'd0);
                    phase = ritp_pkg::PH_DIGITS;
                end
            end
            if (!consumed) begin
                d = digit_of(c);
                if (phase == ritp_pkg::PH_START && hex_on && c == ritp_pkg::CHAR_ZERO) begin
                    phase = ritp_pkg::PH_ZERO;
                end else if ((phase == ritp_pkg::PH_START || phase == ritp_pkg::PH_SIGN_OK) &&
                             c == ritp_pkg::CHAR_MINUS) begin
                    negative = 1'b1;
                    phase    = ritp_pkg::PH_DIGITS;
                end else if (d < {2'b00, radix}) begin
                    add_digit(d);
                    phase = ritp_pkg::PH_DIGITS;
                end else begin
                    done = 1'b1;
                end
            end
            if (eot) begin
                done = 1'b1;
            end
            if (done) begin
                // A number that stops right after a lone zero still counts that zero.
                if (phase == ritp_pkg::PH_ZERO) begin
                    add_digit(8'd0);
                end
                num.value = negative ? -magnitude : magnitude;
                num.count = count;
                num.ovf   = overflowed;
                expected_numbers.push_back(num);
                clear_number();
            end
        endfunction

        function void check_number(logic signed [63:0] value, logic [7:0] n, logic ovf);
            t_parsed_number want;
            if (expected_numbers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: value %0d count %0d overflow %0b",
                             value, n, ovf);
                end
                return;
            end
            want = expected_numbers.pop_front();
            if (value !== want.value || n !== want.count || ovf !== want.ovf) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected value %0d count %0d overflow %0b",
                             $signed(want.value), want.count, want.ovf);
                    $display("                 actual   value %0d count %0d overflow %0b",
                             value, n, ovf);
                end
            end
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_text_char    = '0;
    logic               i_end_of_text  = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic signed [63:0] o_parsed_value;
    logic [7:0]         o_digit_count;
    logic               o_overflow;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index    = 1'b0;
    logic [5:0]         i_cfg_data     = '0;

    t_number_scoreboard numbers;
    int                 sender_idle_pct   = 0;
    int                 receiver_idle_pct = 0;
    int                 items_sent        = 0;
    bit [7:0]           text_buf[$];

    radix_integer_text_parser_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_char    (i_text_char),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_parsed_value (o_parsed_value),
        .o_digit_count  (o_digit_count),
        .o_overflow     (o_overflow),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The run is cut off if it takes far longer than any correct run could.
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: check each accepted item and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            numbers.check_number(o_parsed_value, o_digit_count, o_overflow);
        end
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Offers one character, possibly after a random gap, and waits until it is taken.
    task automatic send_char(input bit [7:0] c, input bit eot);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_text_char   <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        numbers.note_char(c, eot);
        items_sent++;
    endtask

    task automatic send_string(input string s, input bit eot_last);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], eot_last && k == s.len() - 1);
        end
    endtask

    task automatic send_text_buf(input bit eot_last);
        for (int k = 0; k < text_buf.size(); k++) begin
            send_char(text_buf[k], eot_last && k == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    // Stops the input side until every number due has come out and the pipeline is empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (numbers.expected_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back; upper bits of the prefix write are random.
    task automatic write_settings(input bit [5:0] rdx, input bit hex);
        bit [5:0] hex_data;
        hex_data    = {5'($urandom_range(31)), hex};
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ritp_pkg::CFG_RADIX;
        i_cfg_data  <= rdx;
        do @(posedge i_clk); while (!o_cfg_ready);
        numbers.set_register(ritp_pkg::CFG_RADIX, rdx);
        i_cfg_index <= ritp_pkg::CFG_HEX_PREFIX;
        i_cfg_data  <= hex_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        numbers.set_register(ritp_pkg::CFG_HEX_PREFIX, hex_data);
        i_cfg_valid <= 1'b0;
    endtask

    // Letters come out in either case.
    function automatic bit [7:0] digit_char(bit [7:0] d);
        if (d < 10) begin
            return ritp_pkg::CHAR_ZERO + d;
        end
        if ($urandom_range(1) == 1) begin
            return ritp_pkg::CHAR_UPPER_A + d - ritp_pkg::LETTER_DIGIT_BASE;
        end
        return ritp_pkg::CHAR_LOWER_A + d - ritp_pkg::LETTER_DIGIT_BASE;
    endfunction

    // Builds one number of a random kind and sends it.
    task automatic send_random_number(input bit long_run);
        int        kind;
        int        len;
        bit [7:0]  top_digit;
        bit [63:0] m;
        bit [63:0] r;
        bit [7:0]  digs[$];
        bit        eot_last;
        bit        boundary_ok;
        kind        = long_run ? 99 : $urandom_range(99);
        eot_last    = 1'b0;
        boundary_ok = numbers.radix >= 2 && numbers.radix <= 36;
        if (numbers.radix == 0 || numbers.radix > 36) begin
            top_digit = 8'd35;
        end else begin
            top_digit = 8'(numbers.radix) - 8'd1;
        end

        if (kind < 10) begin
            // Noise over the whole character range.
            repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(255)));
            send_text_buf($urandom_range(9) == 0);
            return;
        end
        if (kind < 18) begin
            // Broken sequences built from prefix, sign, space and digit characters.
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(5))
                    0: text_buf.push_back(ritp_pkg::CHAR_ZERO);
                    1: text_buf.push_back(ritp_pkg::CHAR_LOWER_X);
                    2: text_buf.push_back(CHAR_UPPER_X);
                    3: text_buf.push_back(ritp_pkg::CHAR_MINUS);
                    4: text_buf.push_back(CHAR_SPACE);
                    default: text_buf.push_back(digit_char(8'($urandom_range(top_digit))));
                endcase
            end
            send_text_buf($urandom_range(1) == 1);
            return;
        end

        // Well-formed numbers, with an optional prefix and sign.
        if ((numbers.hex_on && $urandom_range(1) == 1) || $urandom_range(19) == 0) begin
            text_buf.push_back(ritp_pkg::CHAR_ZERO);
            text_buf.push_back(ritp_pkg::CHAR_LOWER_X);
        end
        if (kind < 30 && boundary_ok) begin
            // Magnitudes at the edges of the 64-bit range, some one digit too long.
            case ($urandom_range(2))
                0: m = 64'h8000_0000_0000_0000;
                1: m = 64'h7fff_ffff_ffff_ffff;
                default: m = 64'hffff_ffff_ffff_ffff;
            endcase
            if ($urandom_range(1) == 1) begin
                text_buf.push_back(ritp_pkg::CHAR_MINUS);
            end
            r = 64'(numbers.radix);
            do begin
                digs.push_front(8'(m % r));
                m = m / r;
            end while (m != 0);
            if ($urandom_range(3) == 0) begin
                digs.push_back(8'($urandom_range(top_digit)));
            end
            foreach (digs[k]) text_buf.push_back(digit_char(digs[k]));
        end else begin
            if ($urandom_range(99) < 35) begin
                text_buf.push_back(ritp_pkg::CHAR_MINUS);
            end
            if (long_run) begin
                len = 258;
            end else if ($urandom_range(3) == 0) begin
                len = $urandom_range(7, 30);
            end else begin
                len = $urandom_range(1, 6);
            end
            repeat (len) text_buf.push_back(digit_char(8'($urandom_range(top_digit))));
        end

        // End the number with the end flag or with a terminating character.
        if ($urandom_range(9) < 3) begin
            eot_last = 1'b1;
        end else begin
            case ($urandom_range(5))
                0: text_buf.push_back(CHAR_NUL);
                1: text_buf.push_back(CHAR_SPACE);
                2: text_buf.push_back(CHAR_TAB);
                3: text_buf.push_back(CHAR_LF);
                4: text_buf.push_back(CHAR_CR);
                default: text_buf.push_back(8'($urandom_range(255)));
            endcase
            eot_last = ($urandom_range(7) == 0);
        end
        send_text_buf(eot_last);
    endtask

    initial begin
        bit [5:0] radix_plan[NUM_PHASES] = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd0,
                                              6'd1, 6'd63, 6'd37, 6'd8};
        bit       hex_plan[NUM_PHASES]   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                              1'b1, 1'b1, 1'b0, 1'b1};
        int       target;
        numbers = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: radix 10, prefix option off.
        sender_idle_pct   = 30;
        receiver_idle_pct = 84;
        send_string("-12 ", 1'b0);
        send_char(CHAR_SPACE, 1'b0);
        send_string("9", 1'b1);
        send_string("0x", 1'b0);
        send_char(CHAR_TOP, 1'b0);
        send_char(CHAR_NUL, 1'b1);

        // Directed part with the prefix option on in base 16.
        wait_idle();
        write_settings(6'd16, 1'b1);
        send_string("0x-fF", 1'b1);
        send_string("0", 1'b1);
        send_string("07 ", 1'b0);
        send_string("0X1", 1'b1);
        send_string("-\t", 1'b0);

        // Random part, one setting per phase, idle profiles changing every three phases.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                sender_idle_pct   = 30;
                receiver_idle_pct = 84;
            end else if (p < 6) begin
                sender_idle_pct   = 84;
                receiver_idle_pct = 30;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            wait_idle();
            write_settings(radix_plan[p], hex_plan[p]);
            target = items_sent + RANDOM_ITEMS / NUM_PHASES;
            // A binary run long enough to saturate the digit count.
            if (radix_plan[p] == 6'd2) begin
                send_random_number(1'b1);
            end
            while (items_sent < target) begin
                if ($urandom_range(39) == 0) begin
                    wait_idle();
                end
                send_random_number(1'b0);
            end
        end

        wait_idle();
        if (numbers.mismatches == 0 && numbers.expected_numbers.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
